FILE: rtl/multi_timer_bank_top_macros.svh
// Assertion macros for the timer bank.
// Used by the top level only; no other dependencies.
`ifndef MULTI_TIMER_BANK_TOP_MACROS_SVH
`define MULTI_TIMER_BANK_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MTB_ASSERT_IMP(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define MTB_ASSERT_NXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/mtb_pkg.sv
// Package of the timer bank: sizes, request and response codes, word types.
// No dependencies.
package mtb_pkg;
	localparam int NUM_SLOTS = 32;
	localparam int COUNT_WIDTH = 32;
	localparam int SLOT_BITS = $clog2(NUM_SLOTS + 1);
	localparam int IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic [2:0] {
		REQ_ADD = 3'd0, REQ_REMOVE = 3'd1, REQ_PAUSE = 3'd2, REQ_RESUME = 3'd3,
		REQ_TICK = 3'd4, REQ_CLEAR = 3'd5, REQ_RSV6 = 3'd6, REQ_RSV7 = 3'd7
	} req_type_t;

	typedef enum logic [1:0] {
		KIND_ACK = 2'd0, KIND_EXPIRY = 2'd1, KIND_TICK_DONE = 2'd2, KIND_RSV = 2'd3
	} resp_kind_t;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESP} state_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [30:0] timer_id;
		logic        repeat_mode;
		logic [7:0]  group;
		logic [31:0] start_ticks;
		logic [31:0] reload_ticks;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  resp_kind;
		logic        ok;
		logic [30:0] out_id;
		logic [7:0]  out_group;
		logic        last;
	} resp_word_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic               load;     // capture request, reset scan index
		logic               step;     // process slot at index, advance
		logic               finish;   // apply add/find result after scan
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic               scan_end; // index is at the last slot
	} dp_stat_t;
endpackage

FILE: rtl/mtb_ctrl.sv
// Controller of the timer bank: sequences a scan over all slots per request.
// Depends on mtb_pkg.
module mtb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output mtb_pkg::dp_cmd_t  cmd,
	input  mtb_pkg::dp_stat_t stat
);
	import mtb_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (stat.scan_end) state_d = ST_RESP;
			end
			ST_RESP: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

FILE: rtl/mtb_dp.sv
// Datapath of the timer bank: slot storage, one-slot-per-cycle scan, results.
// Depends on mtb_pkg.
module mtb_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  mtb_pkg::req_word_t req,
	input  mtb_pkg::dp_cmd_t   cmd,
	output mtb_pkg::dp_stat_t  stat,
	output logic               result_valid,
	output mtb_pkg::resp_word_t result
);
	import mtb_pkg::*;

	logic [NUM_SLOTS-1:0] active_q, paused_q, periodic_q;
	logic [7:0]           group_q  [NUM_SLOTS];
	logic [30:0]          ident_q  [NUM_SLOTS];
	logic [COUNT_WIDTH-1:0] count_q [NUM_SLOTS];
	logic [COUNT_WIDTH-1:0] reload_q [NUM_SLOTS];
	logic [30:0]          next_id_q;
	req_word_t            req_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic                 hit_q;
	logic [IDX_BITS-1:0]  hit_idx_q;
	logic                 valid_q;
	resp_word_t           result_q;

	logic                 cur_act, cur_pau;
	logic [COUNT_WIDTH-1:0] cur_cnt, dec_cnt;
	logic                 live, expire, id_match, free_slot;
	logic [30:0]          id_inc;

	// Current slot view.
	assign cur_act  = active_q[idx_q];
	assign cur_pau  = paused_q[idx_q];
	assign cur_cnt  = count_q[idx_q];
	assign dec_cnt  = cur_cnt - COUNT_WIDTH'(1);
	assign live     = cur_act && !cur_pau && (cur_cnt != '0);
	assign expire   = (req_q.req_type == REQ_TICK) && live && (dec_cnt == '0);
	assign id_match = cur_act && (ident_q[idx_q] == req_q.timer_id)
		&& (req_q.timer_id != '0);
	assign free_slot = !cur_act;
	assign id_inc = (next_id_q == 31'h7FFF_FFFF) ? 31'd1 : next_id_q + 31'd1;

	assign stat.scan_end = (idx_q == IDX_BITS'(NUM_SLOTS - 1));
	assign result_valid = valid_q;
	assign result = result_q;

	// Control registers: flags, id counter, scan state, result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			paused_q <= '0;
			next_id_q <= 31'd1;
			idx_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			valid_q <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) group_q[i] <= '0;
		end else begin
			valid_q <= 1'b0;
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end
			if (cmd.step) begin
				if (!stat.scan_end) idx_q <= idx_q + IDX_BITS'(1);
				unique case (req_q.req_type)
					REQ_ADD: if (!hit_q && free_slot) begin
						hit_q <= 1'b1;
						hit_idx_q <= idx_q;
					end
					REQ_REMOVE, REQ_PAUSE, REQ_RESUME: if (!hit_q && id_match) begin
						hit_q <= 1'b1;
						hit_idx_q <= idx_q;
					end
					REQ_TICK: if (expire && !periodic_q[idx_q])
						active_q[idx_q] <= 1'b0;
					REQ_CLEAR: if (group_q[idx_q] == req_q.group)
						active_q[idx_q] <= 1'b0;
					default: ;
				endcase
			end
			if (expire && cmd.step) valid_q <= 1'b1;
			if (cmd.finish) begin
				valid_q <= 1'b1;
				if (hit_q) begin
					unique case (req_q.req_type)
						REQ_ADD: begin
							active_q[hit_idx_q] <= 1'b1;
							paused_q[hit_idx_q] <= 1'b0;
							group_q[hit_idx_q] <= req_q.group;
							next_id_q <= id_inc;
						end
						REQ_REMOVE: active_q[hit_idx_q] <= 1'b0;
						REQ_PAUSE:  paused_q[hit_idx_q] <= 1'b1;
						REQ_RESUME: paused_q[hit_idx_q] <= 1'b0;
						default: ;
					endcase
				end
			end
		end
	end

	// Payload registers: request capture, slot data, result word.
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.step && req_q.req_type == REQ_TICK && live)
			count_q[idx_q] <= (dec_cnt == '0) ? reload_q[idx_q] : dec_cnt;
		if (cmd.step && expire) begin
			result_q.resp_kind <= KIND_EXPIRY;
			result_q.ok <= 1'b1;
			result_q.out_id <= ident_q[idx_q];
			result_q.out_group <= group_q[idx_q];
			result_q.last <= 1'b0;
		end
		if (cmd.finish) begin
			result_q.resp_kind <= (req_q.req_type == REQ_TICK) ? KIND_TICK_DONE : KIND_ACK;
			result_q.ok <= !(req_q.req_type == REQ_ADD && !hit_q);
			result_q.out_id <= (req_q.req_type == REQ_ADD && hit_q) ? next_id_q : '0;
			result_q.out_group <= '0;
			result_q.last <= 1'b1;
			if (req_q.req_type == REQ_ADD && hit_q) begin
				periodic_q[hit_idx_q] <= req_q.repeat_mode;
				ident_q[hit_idx_q] <= next_id_q;
				count_q[hit_idx_q] <= req_q.start_ticks[COUNT_WIDTH-1:0];
				reload_q[hit_idx_q] <= req_q.reload_ticks[COUNT_WIDTH-1:0];
			end
		end
	end
endmodule

FILE: rtl/multi_timer_bank_top.sv
// Top level of the timer bank: controller plus datapath.
// Depends on mtb_pkg, mtb_ctrl, mtb_dp and the assertion macro header.
//
// Usage: drive a request word on req and raise start while busy is low; the
// word is taken at that edge. Every request scans all NUM_SLOTS slots, one
// slot per cycle through the slot datapath, then takes a finish step; busy
// is high during the scan and finish steps.
// Results appear on result with result_valid high for one cycle each. A tick
// gives one expiry word per firing slot during its scan, in slot order,
// then a tick-finished word with last set. Other requests give one
// acknowledge word with last set, registered from the finish step.
// The receiver cannot stall; each word must be taken in its cycle.
// Reset clears the active and pause flags and groups, sets the id counter to
// one, and leaves the block idle; no clearing pass is needed.
module multi_timer_bank_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  mtb_pkg::req_word_t   req,
	output logic                 result_valid,
	output mtb_pkg::resp_word_t  result
);
	import mtb_pkg::*;
	`include "multi_timer_bank_top_macros.svh"

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mtb_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd, .stat);
	mtb_dp   u_dp (.clk, .arst_n, .req, .cmd, .stat, .result_valid, .result);

	// Only one command at a time from the controller.
	`MTB_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")
	// An accepted request makes the block busy next cycle.
	`MTB_ASSERT_NXT(a_busy_after, start && !busy, busy, "busy not raised after accept")
	// Each finish command yields a result word with last set.
	`MTB_ASSERT_NXT(a_last_fin, cmd.finish, result_valid && result.last, "missing final word")
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the timer bank top level.
// Depends on mtb_pkg and multi_timer_bank_top; predicts results in place.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mtb_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_word_t req;
	logic result_valid;
	resp_word_t result;

	multi_timer_bank_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result)
	);

	// Predicted bank contents.
	bit          bank_active [NUM_SLOTS];
	bit          bank_paused [NUM_SLOTS];
	bit          bank_periodic [NUM_SLOTS];
	bit [30:0]   bank_ident [NUM_SLOTS];
	bit [7:0]    bank_group [NUM_SLOTS];
	bit [31:0]   bank_count [NUM_SLOTS];
	bit [31:0]   bank_reload [NUM_SLOTS];
	bit [30:0]   ident_next;

	req_word_t   pending_words [$];
	resp_word_t  expected_words [$];
	int          idle_pct;
	bit          hold_sender;
	bit          stim_done;
	int          errors;
	int          ids_seen [$];

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic resp_word_t mk(logic [1:0] k, logic o, logic [30:0] id,
			logic [7:0] g, logic l);
		resp_word_t r;
		r.resp_kind = k;
		r.ok = o;
		r.out_id = id;
		r.out_group = g;
		r.last = l;
		return r;
	endfunction

	// Apply one accepted request to the predicted bank and queue its words.
	task automatic predict_request(input req_word_t w);
		int i;
		int hit;
		hit = -1;
		case (req_type_t'(w.req_type))
			REQ_ADD: begin
				for (i = 0; i < NUM_SLOTS; i++)
					if (!bank_active[i] && hit < 0) hit = i;
				if (hit < 0) begin
					expected_words.push_back(mk(KIND_ACK, 1'b0, '0, '0, 1'b1));
				end else begin
					bank_active[hit] = 1;
					bank_paused[hit] = 0;
					bank_periodic[hit] = w.repeat_mode;
					bank_group[hit] = w.group;
					bank_count[hit] = w.start_ticks;
					bank_reload[hit] = w.reload_ticks;
					bank_ident[hit] = ident_next;
					expected_words.push_back(mk(KIND_ACK, 1'b1, ident_next, '0, 1'b1));
					ident_next = ident_next + 31'd1;
					if (ident_next == 0) ident_next = 1;
				end
			end
			REQ_REMOVE, REQ_PAUSE, REQ_RESUME: begin
				if (w.timer_id != 0)
					for (i = 0; i < NUM_SLOTS; i++)
						if (hit < 0 && bank_active[i] && bank_ident[i] == w.timer_id)
							hit = i;
				if (hit >= 0) begin
					if (w.req_type == REQ_REMOVE) bank_active[hit] = 0;
					else bank_paused[hit] = (w.req_type == REQ_PAUSE);
				end
				expected_words.push_back(mk(KIND_ACK, 1'b1, '0, '0, 1'b1));
			end
			REQ_TICK: begin
				for (i = 0; i < NUM_SLOTS; i++) begin
					if (bank_active[i] && !bank_paused[i] && bank_count[i] != 0) begin
						bank_count[i] = bank_count[i] - 1;
						if (bank_count[i] == 0) begin
							expected_words.push_back(mk(KIND_EXPIRY, 1'b1, bank_ident[i],
								bank_group[i], 1'b0));
							if (bank_periodic[i]) bank_count[i] = bank_reload[i];
							else bank_active[i] = 0;
						end
					end
				end
				expected_words.push_back(mk(KIND_TICK_DONE, 1'b1, '0, '0, 1'b1));
			end
			REQ_CLEAR: begin
				for (i = 0; i < NUM_SLOTS; i++)
					if (bank_group[i] == w.group) bank_active[i] = 0;
				expected_words.push_back(mk(KIND_ACK, 1'b1, '0, '0, 1'b1));
			end
			default: expected_words.push_back(mk(KIND_ACK, 1'b1, '0, '0, 1'b1));
		endcase
	endtask

	// Driver: offer the next queued word, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				predict_request(req);
				void'(pending_words.pop_front());
			end
			if (pending_words.size() > 0 && !hold_sender &&
					$urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				req <= pending_words[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each result word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %p", $realtime, result);
				errors++;
			end else begin
				if (expected_words[0] !== result) begin
					$display("%0t: mismatch, expected %p, actual %p", $realtime,
						expected_words[0], result);
					errors++;
				end
				void'(expected_words.pop_front());
			end
		end
	end

	function automatic req_word_t word_of(req_type_t t, logic [30:0] id, logic m,
			logic [7:0] g, logic [31:0] s, logic [31:0] r);
		req_word_t w;
		w.req_type = t;
		w.timer_id = id;
		w.repeat_mode = m;
		w.group = g;
		w.start_ticks = s;
		w.reload_ticks = r;
		return w;
	endfunction

	// Random request mostly aimed at live ids and small counts.
	function automatic req_word_t random_word();
		int sel;
		logic [30:0] id;
		logic [31:0] s;
		logic [31:0] r;
		sel = $urandom_range(99);
		id = 31'((ids_seen.size() > 0 && $urandom_range(3) != 0) ?
			ids_seen[$urandom_range(ids_seen.size() - 1)] : $urandom);
		s = ($urandom_range(9) == 0) ? $urandom : $urandom_range(6);
		r = ($urandom_range(9) == 0) ? $urandom : $urandom_range(5);
		if (sel < 30) return word_of(REQ_ADD, 31'($urandom), 1'($urandom_range(1)),
			8'($urandom_range(7)), s, r);
		if (sel < 38) return word_of(REQ_REMOVE, id, 1'($urandom_range(1)), 8'($urandom),
			s, r);
		if (sel < 45) return word_of(REQ_PAUSE, id, 1'b0, 8'($urandom), s, r);
		if (sel < 52) return word_of(REQ_RESUME, id, 1'b1, 8'($urandom), s, r);
		if (sel < 90) return word_of(REQ_TICK, 31'($urandom), 1'($urandom_range(1)),
			8'($urandom), $urandom, $urandom);
		if (sel < 96) return word_of(REQ_CLEAR, id, 1'b0, 8'($urandom_range(7)), s, r);
		return word_of(req_type_t'($urandom_range(7, 6)), 31'($urandom), 1'b1, 8'($urandom),
			$urandom, $urandom);
	endfunction

	task automatic drain();
		while (pending_words.size() > 0 || expected_words.size() > 0 || busy)
			@(posedge clk);
	endtask

	initial begin
		int i;
		int phase;
		errors = 0;
		stim_done = 0;
		hold_sender = 0;
		idle_pct = 0;
		ident_next = 1;
		for (i = 0; i < NUM_SLOTS; i++) begin
			bank_active[i] = 0;
			bank_paused[i] = 0;
			bank_group[i] = 0;
		end
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every request code, full bank, zero id, zero reload.
		pending_words.push_back(word_of(REQ_ADD, '1, 1, 8'hFF, 32'd1, 32'd0));
		pending_words.push_back(word_of(REQ_ADD, '0, 0, 8'h00, 32'hFFFF_FFFF, '1));
		pending_words.push_back(word_of(REQ_ADD, '0, 1, 8'h5A, 32'd2, 32'd2));
		pending_words.push_back(word_of(REQ_ADD, '0, 0, 8'hA5, 32'd0, 32'd3));
		pending_words.push_back(word_of(REQ_TICK, '1, 1, 8'hFF, '1, '1));
		pending_words.push_back(word_of(REQ_TICK, '0, 0, 8'h00, '0, '0));
		pending_words.push_back(word_of(REQ_PAUSE, 31'd3, 0, 0, 0, 0));
		pending_words.push_back(word_of(REQ_TICK, 0, 0, 0, 0, 0));
		pending_words.push_back(word_of(REQ_RESUME, 31'd3, 0, 0, 0, 0));
		pending_words.push_back(word_of(REQ_REMOVE, 31'd0, 0, 0, 0, 0));
		pending_words.push_back(word_of(REQ_REMOVE, 31'h7FFF_FFFF, 0, 0, 0, 0));
		pending_words.push_back(word_of(REQ_REMOVE, 31'd2, 0, 0, 0, 0));
		pending_words.push_back(word_of(REQ_CLEAR, 0, 0, 8'h5A, 0, 0));
		pending_words.push_back(word_of(REQ_CLEAR, 0, 0, 8'h33, 0, 0));
		pending_words.push_back(word_of(REQ_RSV6, '1, 1, 8'hFF, '1, '1));
		pending_words.push_back(word_of(REQ_RSV7, 0, 0, 0, 0, 0));
		for (i = 0; i < 33; i++)
			pending_words.push_back(word_of(REQ_ADD, 0, i[0], 8'd9, 32'd1, 32'd1));
		pending_words.push_back(word_of(REQ_TICK, 0, 0, 0, 0, 0));
		pending_words.push_back(word_of(REQ_CLEAR, 0, 0, 8'd9, 0, 0));
		pending_words.push_back(word_of(REQ_CLEAR, 0, 0, 8'hFF, 0, 0));
		pending_words.push_back(word_of(REQ_CLEAR, 0, 0, 8'h00, 0, 0));
		pending_words.push_back(word_of(REQ_CLEAR, 0, 0, 8'hA5, 0, 0));
		drain();

		// Random phases: no idling, sender idle 77%, no idling again, sender idle 13%.
		for (phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1) ? 77 : (phase == 3 ? 13 : 0);
			for (i = 0; i < 90; i++) begin
				ids_seen.push_back(int'(ident_next) + $urandom_range(3) - 2);
				if (ids_seen.size() > 40) void'(ids_seen.pop_front());
				pending_words.push_back(random_word());
				while (pending_words.size() > 2) @(posedge clk);
			end
			// Sender sends what is queued, then waits until every expected word has come.
			while (pending_words.size() > 0) @(posedge clk);
			hold_sender = 1;
			drain();
			hold_sender = 0;
		end
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Hard limit on run time.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end
endmodule
